// ===== rtl/otptt_pkg.sv =====
// otptt_pkg: shared codes, widths and controller/datapath types for the timer table.
// No dependencies; compiled first.
`default_nettype none

package otptt_pkg;

  localparam int MAX_SLOTS = 32;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 6;
  localparam int TICKS_W  = 32;
  localparam int COUNT_W  = 64;
  localparam int KIND_W   = 2;
  localparam int RSLOT_W  = 5;

  typedef logic [CMD_W-1:0]  cmd_code_t;
  typedef logic [1:0]        slot_st_t;
  typedef logic [KIND_W-1:0] kind_t;

  // command codes
  localparam cmd_code_t CMD_TICK   = 3'd0;
  localparam cmd_code_t CMD_CREATE = 3'd1;
  localparam cmd_code_t CMD_DELETE = 3'd2;
  localparam cmd_code_t CMD_STOP   = 3'd3;
  localparam cmd_code_t CMD_START  = 3'd4;

  // slot states
  localparam slot_st_t ST_FREE    = 2'd0;
  localparam slot_st_t ST_ACTIVE  = 2'd1;
  localparam slot_st_t ST_EXPIRED = 2'd2;
  localparam slot_st_t ST_STOPPED = 2'd3;

  // result kinds
  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_FIRE   = 2'd1;
  localparam kind_t KIND_IDLE   = 2'd2;

  // output register source select
  localparam logic [1:0] OSEL_STATUS = 2'd0;
  localparam logic [1:0] OSEL_FIRE   = 2'd1;
  localparam logic [1:0] OSEL_IDLE   = 2'd2;

  // expiry write source
  localparam logic EXP_SRC_DELAY  = 1'b0;
  localparam logic EXP_SRC_RELOAD = 1'b1;

  // number of slots actually built
  function automatic int table_size(input int n);
    if (n > MAX_SLOTS) return MAX_SLOTS;
    if (n < 1) return 1;
    return n;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic       tick_inc;
    logic       addr_clr;
    logic       addr_load_id;
    logic       addr_inc;
    logic       stat_we;
    slot_st_t   stat_wval;
    logic       exp_we;
    logic       exp_src;
    logic       rel_we;
    logic       hold_set;
    logic       hold_clr;
    logic       resp_set;
    logic       resp_err;
    logic       resp_use_addr;
    logic       out_load;
    logic [1:0] out_sel;
    logic       out_last;
  } otptt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      id_ok;
    logic      delay_zero;
    logic      stat_free;
    logic      stat_active;
    logic      fire;
    logic      reload_zero;
    logic      at_last;
    logic      hold_valid;
    logic      out_free;
  } otptt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/otptt_in_if.sv =====
// otptt_in_if: request channel (valid/ready plus command payload).
// Depends on otptt_pkg.
`default_nettype none

interface otptt_in_if import otptt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cmd_code_t            cmd;
  logic [ID_W-1:0]      slot_id;
  logic [TICKS_W-1:0]   delay_ticks;
  logic [TICKS_W-1:0]   period_ticks;

  modport source (output valid, cmd, slot_id, delay_ticks, period_ticks, input ready);
  modport sink   (input valid, cmd, slot_id, delay_ticks, period_ticks, output ready);
endinterface

`default_nettype wire

// ===== rtl/otptt_out_if.sv =====
// otptt_out_if: result channel (valid/ready plus result payload).
// Depends on otptt_pkg.
`default_nettype none

interface otptt_out_if import otptt_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic               error;
  logic [RSLOT_W-1:0] result_slot;
  logic               last;

  modport source (output valid, kind, error, result_slot, last, input ready);
  modport sink   (input valid, kind, error, result_slot, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/otptt_ram.sv =====
// otptt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module otptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/otptt_datapath.sv =====
// otptt_datapath: tick counter, slot state flops, expiry/reload RAMs, scan address,
// pending fire holder and output register. Depends on otptt_pkg, otptt_ram.
`default_nettype none

module otptt_datapath import otptt_pkg::*; #(
  parameter int NUM_TIMERS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request payload
  input  wire logic               in_acc,
  input  wire cmd_code_t          in_cmd,
  input  wire logic [ID_W-1:0]    in_slot_id,
  input  wire logic [TICKS_W-1:0] in_delay_ticks,
  input  wire logic [TICKS_W-1:0] in_period_ticks,
  // result channel
  input  wire logic               out_ready,
  output logic                    out_valid,
  output kind_t                   out_kind,
  output logic                    out_error,
  output logic [RSLOT_W-1:0]      out_result_slot,
  output logic                    out_last,
  // controller link
  input  wire otptt_cmd_t         ctl,
  output otptt_sts_t              sts
);

  localparam int TS = table_size(NUM_TIMERS);
  localparam int IW = (TS > 1) ? $clog2(TS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TS - 1);

  // latched request
  cmd_code_t          cmd_r;
  logic [ID_W-1:0]    id_r;
  logic [TICKS_W-1:0] delay_r, period_r;
  logic               id_ok_r;

  logic [COUNT_W-1:0] tick_r;
  logic [IW-1:0]      addr_r;
  slot_st_t           status_r [TS];

  logic               hold_valid_r;
  logic [IW-1:0]      hold_slot_r;
  logic               resp_err_r;
  logic [RSLOT_W-1:0] resp_slot_r;

  logic               out_valid_r, out_err_r, out_last_r;
  kind_t              out_kind_r;
  logic [RSLOT_W-1:0] out_slot_r;

  logic [COUNT_W-1:0] exp_rd, exp_wdata;
  logic [TICKS_W-1:0] rel_rd;
  slot_st_t           stat_rd;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_cmd;
      id_r     <= in_slot_id;
      delay_r  <= in_delay_ticks;
      period_r <= in_period_ticks;
      id_ok_r  <= ({1'b0, in_slot_id} < (ID_W + 1)'(TS));
    end
  end

  // slot state read at the scan/command address
  always_comb begin
    stat_rd = ST_FREE;
    for (int i = 0; i < TS; i++) begin
      if (addr_r == IW'(i)) stat_rd = status_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      hold_valid_r <= 1'b0;
      for (int i = 0; i < TS; i++) status_r[i] <= ST_FREE;
    end else begin
      if (ctl.tick_inc) tick_r <= tick_r + COUNT_W'(1);
      if (ctl.hold_clr) hold_valid_r <= 1'b0;
      else if (ctl.hold_set) hold_valid_r <= 1'b1;
      for (int i = 0; i < TS; i++) begin
        if (ctl.stat_we && addr_r == IW'(i)) status_r[i] <= ctl.stat_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.addr_clr) addr_r <= '0;
    else if (ctl.addr_load_id) addr_r <= id_r[IW-1:0];
    else if (ctl.addr_inc) addr_r <= addr_r + IW'(1);
    if (ctl.hold_set) hold_slot_r <= addr_r;
    if (ctl.resp_set) begin
      resp_err_r  <= ctl.resp_err;
      resp_slot_r <= ctl.resp_use_addr ? RSLOT_W'(addr_r) : '0;
    end
  end

  assign exp_wdata = (ctl.exp_src == EXP_SRC_RELOAD) ? tick_r + COUNT_W'(rel_rd)
                                                     : tick_r + COUNT_W'(delay_r);

  otptt_ram #(.WIDTH(COUNT_W), .DEPTH(TS)) u_exp_ram (
    .clk   (clk),
    .we    (ctl.exp_we),
    .waddr (addr_r),
    .wdata (exp_wdata),
    .raddr (addr_r),
    .rdata (exp_rd)
  );

  otptt_ram #(.WIDTH(TICKS_W), .DEPTH(TS)) u_rel_ram (
    .clk   (clk),
    .we    (ctl.rel_we),
    .waddr (addr_r),
    .wdata (period_r),
    .raddr (addr_r),
    .rdata (rel_rd)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_last_r <= ctl.out_last;
      case (ctl.out_sel)
        OSEL_FIRE: begin
          out_kind_r <= KIND_FIRE;
          out_err_r  <= 1'b0;
          out_slot_r <= RSLOT_W'(hold_slot_r);
        end
        OSEL_IDLE: begin
          out_kind_r <= KIND_IDLE;
          out_err_r  <= 1'b0;
          out_slot_r <= '0;
        end
        default: begin
          out_kind_r <= KIND_STATUS;
          out_err_r  <= resp_err_r;
          out_slot_r <= resp_slot_r;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_error       = out_err_r;
  assign out_result_slot = out_slot_r;
  assign out_last        = out_last_r;

  always_comb begin
    sts.cmd         = cmd_r;
    sts.id_ok       = id_ok_r;
    sts.delay_zero  = (delay_r == '0);
    sts.stat_free   = (stat_rd == ST_FREE);
    sts.stat_active = (stat_rd == ST_ACTIVE);
    sts.fire        = (stat_rd == ST_ACTIVE) && (tick_r >= exp_rd);
    sts.reload_zero = (rel_rd == '0);
    sts.at_last     = (addr_r == LAST_IDX);
    sts.hold_valid  = hold_valid_r;
    sts.out_free    = out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/otptt_ctrl.sv =====
// otptt_ctrl: sequencer that dispatches each request and steps the datapath.
// Depends on otptt_pkg.
`default_nettype none

module otptt_ctrl import otptt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_acc,
  output logic            in_ready,
  input  wire otptt_sts_t sts,
  output otptt_cmd_t      ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_TWAIT = 3'd2;
  localparam logic [2:0] S_TEVAL = 3'd3;
  localparam logic [2:0] S_TFIN  = 3'd4;
  localparam logic [2:0] S_CSCAN = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ok;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    ok        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_TICK: begin
            ctl.tick_inc = 1'b1;
            ctl.addr_clr = 1'b1;
            ctl.hold_clr = 1'b1;
            state_nxt    = S_TWAIT;
          end
          CMD_CREATE: begin
            if (sts.delay_zero) begin
              ctl.resp_set = 1'b1;
              ctl.resp_err = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              ctl.addr_clr = 1'b1;
              state_nxt    = S_CSCAN;
            end
          end
          CMD_DELETE, CMD_STOP, CMD_START: begin
            ctl.addr_load_id = 1'b1;
            state_nxt        = S_CHECK;
          end
          default: begin
            ctl.resp_set = 1'b1;
            ctl.resp_err = 1'b1;
            state_nxt    = S_RESP;
          end
        endcase
      end
      S_TWAIT: begin
        state_nxt = S_TEVAL;
      end
      S_TEVAL: begin
        // a second fire must push the held one out first
        if (!(sts.fire && sts.hold_valid && !sts.out_free)) begin
          if (sts.fire) begin
            if (sts.reload_zero) begin
              ctl.stat_we   = 1'b1;
              ctl.stat_wval = ST_EXPIRED;
            end else begin
              ctl.exp_we  = 1'b1;
              ctl.exp_src = EXP_SRC_RELOAD;
            end
            if (sts.hold_valid) begin
              ctl.out_load = 1'b1;
              ctl.out_sel  = OSEL_FIRE;
              ctl.out_last = 1'b0;
            end
            ctl.hold_set = 1'b1;
          end
          if (sts.at_last) begin
            state_nxt = S_TFIN;
          end else begin
            ctl.addr_inc = 1'b1;
            state_nxt    = S_TWAIT;
          end
        end
      end
      S_TFIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = sts.hold_valid ? OSEL_FIRE : OSEL_IDLE;
          ctl.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CSCAN: begin
        if (sts.stat_free) begin
          ctl.stat_we       = 1'b1;
          ctl.stat_wval     = ST_ACTIVE;
          ctl.exp_we        = 1'b1;
          ctl.exp_src       = EXP_SRC_DELAY;
          ctl.rel_we        = 1'b1;
          ctl.resp_set      = 1'b1;
          ctl.resp_err      = 1'b0;
          ctl.resp_use_addr = 1'b1;
          state_nxt         = S_RESP;
        end else if (sts.at_last) begin
          ctl.resp_set = 1'b1;
          ctl.resp_err = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          ctl.addr_inc = 1'b1;
        end
      end
      S_CHECK: begin
        case (sts.cmd)
          CMD_DELETE: begin
            ok            = sts.id_ok && !sts.stat_free;
            ctl.stat_we   = ok;
            ctl.stat_wval = ST_FREE;
          end
          CMD_STOP: begin
            ok            = sts.id_ok && sts.stat_active;
            ctl.stat_we   = ok;
            ctl.stat_wval = ST_STOPPED;
          end
          CMD_START: begin
            ok            = sts.id_ok && !sts.stat_free;
            ctl.stat_we   = ok;
            ctl.stat_wval = ST_ACTIVE;
            ctl.exp_we    = ok && !sts.delay_zero;
            ctl.exp_src   = EXP_SRC_DELAY;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        ctl.resp_set = 1'b1;
        ctl.resp_err = !ok;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = OSEL_STATUS;
          ctl.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/oneshot_periodic_timer_table_unit.sv =====
// Timer table top level: one request at a time; the output register lets the next
// request in while a result waits. Tick: every slot is scanned with a RAM read, then a
// compare, and the scan may wait on the result side. Create: free-slot search, one slot
// per cycle. Delete/stop/start: check of the addressed slot. Zero-delay create or unknown command: respond directly.
// Reset (synchronous, rst_n low): tick count cleared, all slots free, no result pending.
// Expiry and reload RAMs need no clearing; a scan only uses the entries of active slots.
`default_nettype none

module oneshot_periodic_timer_table_unit import otptt_pkg::*; #(
  parameter int NUM_TIMERS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  otptt_in_if.sink    in_req,
  otptt_out_if.source out_rsp
);

  // TS = NUM_TIMERS clamped to the range 1 to 32; that many slots are built.

  otptt_cmd_t ctl;   // sequencer commands
  otptt_sts_t sts;   // datapath status
  logic       in_acc;
  logic       ready;

  // request accepted on valid && ready
  assign in_acc       = in_req.valid && ready;
  assign in_req.ready = ready;

  // Sequencer: per request, dispatch -> (scan | check) -> respond; a bad create goes straight to respond.
  // Tick scans every slot, holding each fire until the next is found so the
  // final one can carry last.
  otptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_ready (ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: tick count, slot states, expiry/reload RAMs, output register.
  otptt_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .in_cmd          (in_req.cmd),
    .in_slot_id      (in_req.slot_id),
    .in_delay_ticks  (in_req.delay_ticks),
    .in_period_ticks (in_req.period_ticks),
    .out_ready       (out_rsp.ready),
    .out_valid       (out_rsp.valid),
    .out_kind        (out_rsp.kind),
    .out_error       (out_rsp.error),
    .out_result_slot (out_rsp.result_slot),
    .out_last        (out_rsp.last),
    .ctl             (ctl),
    .sts             (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/otptt_checker.sv =====
// otptt_checker: port-level checks for the timer table, bound to the top level.
// Depends on otptt_pkg.
`default_nettype none

module otptt_checker import otptt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire kind_t              out_kind,
  input wire logic               out_error,
  input wire logic [RSLOT_W-1:0] out_result_slot,
  input wire logic               out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_error)
      && $stable(out_result_slot) && $stable(out_last)))
    else $error("result changed while stalled");

  // one request in flight: accept drops ready next cycle
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // command status is always the only result of its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_STATUS) |-> out_last)
    else $error("status result without last");

  // idle tick result carries no error, slot zero, last set; fire has no error
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_IDLE || out_kind == KIND_FIRE)) |->
      (!out_error && (out_kind == KIND_FIRE || (out_last && out_result_slot == '0))))
    else $error("bad fields on tick result");

endmodule

bind oneshot_periodic_timer_table_unit otptt_checker u_otptt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_kind        (out_rsp.kind),
  .out_error       (out_rsp.error),
  .out_result_slot (out_rsp.result_slot),
  .out_last        (out_rsp.last)
);

`default_nettype wire
